>>> hw/rtl/texture_coverage_histogram_defines.svh
// Assertion macros shared by the texture coverage histogram checker.
`ifndef TEXTURE_COVERAGE_HISTOGRAM_DEFINES_SVH
`define TEXTURE_COVERAGE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define TCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("texture coverage histogram check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define TCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("texture coverage histogram check failed");

`endif

>>> hw/rtl/tch_pkg.sv
// Constants, types and helper functions of the texture coverage histogram.
package tch_pkg;

  localparam int GRID_SIZE = 10;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int GRID_W    = $clog2(GRID_SIZE + 1);

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int CNT_W     = 24;
  localparam int COV_W     = 9;

  // Signed product of a coordinate and the grid size, with room for the sign.
  localparam int PROD_W    = COORD_W + GRID_W + 1;

  localparam logic signed [PROD_W-1:0] GRID_MUL = PROD_W'(GRID_SIZE);
  localparam logic signed [PROD_W-1:0] HI_LIM   = PROD_W'(GRID_SIZE) <<< FRAC_W;
  localparam logic signed [PROD_W-1:0] LO_LIM   = -(PROD_W'(1) <<< FRAC_W);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic             on_grid;
    logic [IDX_W-1:0] idx;
  } coord_t;

  // Scales one Q15.16 coordinate by the grid size and truncates towards zero.
  // A scaled value between minus one and zero lands in cell zero.
  function automatic coord_t tch_cell_coord(input logic signed [COORD_W-1:0] c);
    logic signed [PROD_W-1:0] prod;
    coord_t                   res;
    prod        = PROD_W'(c) * GRID_MUL;
    res.on_grid = (prod > LO_LIM) && (prod < HI_LIM);
    res.idx     = prod[PROD_W-1] ? '0 : prod[FRAC_W +: IDX_W];
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] tch_sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

>>> hw/rtl/texture_coverage_histogram.sv
// Top level of the texture coverage histogram: input register, map update, result register.
//
// Usage
//   Input channel (in_valid / in_ready) carries one vertex per transfer: the
//   texture coordinates in_tex_s and in_tex_t in signed Q15.16 and in_last,
//   which marks the final vertex of a mesh.
//   Output channel (out_valid / out_ready) carries one result per mesh: vertex,
//   outside and covered-cell counts, sent for the vertex marked last.
//   A last vertex passes the input register; its result is held in the result register.
//   Throughput: one vertex per cycle, but a last vertex waits while a result is pending.
//   In the input register both coordinates are scaled by a constant multiply and the
//   coverage bitmap (one flip-flop per cell) and counters are updated.
//   After a last vertex the bitmap and counters are cleared at once, so the
//   next mesh may follow in the very next cycle.
//   Reset (rst_n low at a clock edge) empties both registers, clears the bitmap
//   and all counters.
//   When the receiver stalls, the result is held in the output register and
//   ordinary vertices keep flowing; only a further last vertex waits in the
//   input register until the pending result has been taken.
module texture_coverage_histogram (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tch_pkg::COORD_W-1:0]  in_tex_s,
  input  logic signed [tch_pkg::COORD_W-1:0]  in_tex_t,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [tch_pkg::CNT_W-1:0]    out_vertex_count,
  output logic        [tch_pkg::CNT_W-1:0]    out_outside_count,
  output logic        [tch_pkg::COV_W-1:0]    out_covered_cells
);
  import tch_pkg::*;

  // Input register
  logic                       s1_valid_r;
  logic signed [COORD_W-1:0]  s1_s_r;
  logic signed [COORD_W-1:0]  s1_t_r;
  logic                       s1_last_r;

  // Running state of the current mesh
  logic [CELLS-1:0]           map_r;
  logic [CELLS-1:0]           map_nxt;
  logic [CNT_W-1:0]           vcnt_r;
  logic [CNT_W-1:0]           vcnt_nxt;
  logic [CNT_W-1:0]           ocnt_r;
  logic [CNT_W-1:0]           ocnt_nxt;
  logic [COV_W-1:0]           ccnt_r;
  logic [COV_W-1:0]           ccnt_nxt;

  // Result register
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [CNT_W-1:0]           out_vcnt_r;
  logic [CNT_W-1:0]           out_ocnt_r;
  logic [COV_W-1:0]           out_ccnt_r;

  coord_t                     s_c;
  coord_t                     t_c;
  logic                       pair_on_grid;
  logic [CELL_W-1:0]          cell_idx;
  logic                       hit_new;
  logic                       res_free;
  logic                       s1_adv;

  always_comb begin
    s_c          = tch_cell_coord(s1_s_r);
    t_c          = tch_cell_coord(s1_t_r);
    pair_on_grid = s_c.on_grid && t_c.on_grid;
    cell_idx     = CELL_W'(s_c.idx) * CELL_W'(GRID_SIZE) + CELL_W'(t_c.idx);
    hit_new      = pair_on_grid && !map_r[cell_idx];

    res_free = !out_valid_r || out_ready;
    // Only a last vertex needs the result register to be free.
    s1_adv   = s1_valid_r && (!s1_last_r || res_free);
    in_ready = !s1_valid_r || s1_adv;

    vcnt_nxt = tch_sat_inc(vcnt_r);
    ocnt_nxt = pair_on_grid ? ocnt_r : tch_sat_inc(ocnt_r);
    ccnt_nxt = ccnt_r + COV_W'(hit_new);
    for (int i = 0; i < CELLS; i++) begin
      map_nxt[i] = map_r[i] || (pair_on_grid && (cell_idx == CELL_W'(i)));
    end

    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      map_r       <= '0;
      vcnt_r      <= '0;
      ocnt_r      <= '0;
      ccnt_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        if (s1_last_r) begin
          map_r  <= '0;
          vcnt_r <= '0;
          ocnt_r <= '0;
          ccnt_r <= '0;
        end else begin
          map_r  <= map_nxt;
          vcnt_r <= vcnt_nxt;
          ocnt_r <= ocnt_nxt;
          ccnt_r <= ccnt_nxt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_s_r    <= in_tex_s;
      s1_t_r    <= in_tex_t;
      s1_last_r <= in_last;
    end
    if (s1_adv && s1_last_r) begin
      out_vcnt_r <= vcnt_nxt;
      out_ocnt_r <= ocnt_nxt;
      out_ccnt_r <= ccnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_count  = out_vcnt_r;
  assign out_outside_count = out_ocnt_r;
  assign out_covered_cells = out_ccnt_r;

endmodule

>>> hw/rtl/tch_checker.sv
// Port-level assertions for the texture coverage histogram, bound to its top level.
`include "texture_coverage_histogram_defines.svh"

module tch_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [tch_pkg::COORD_W-1:0]  in_tex_s,
  input logic signed [tch_pkg::COORD_W-1:0]  in_tex_t,
  input logic                                in_last,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic        [tch_pkg::CNT_W-1:0]    out_vertex_count,
  input logic        [tch_pkg::CNT_W-1:0]    out_outside_count,
  input logic        [tch_pkg::COV_W-1:0]    out_covered_cells
);
  import tch_pkg::*;

  // An offered vertex stays on the input, unchanged, until its transfer.
  `TCH_ASSERT_NXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(in_tex_s) && $stable(in_tex_t) && $stable(in_last))

  // A stalled result must keep its counts until the transfer.
  `TCH_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_vertex_count) && $stable(out_outside_count)
    && $stable(out_covered_cells))

  // Every result counts at least the last vertex itself.
  `TCH_ASSERT_IMP(a_vertex_nonzero, out_valid, out_vertex_count != '0)

  // Outside vertices are a subset of all vertices.
  `TCH_ASSERT_IMP(a_outside_le_vertex, out_valid, out_outside_count <= out_vertex_count)

  // The covered count can never pass the number of grid cells.
  `TCH_ASSERT_IMP(a_covered_le_cells, out_valid, out_covered_cells <= COV_W'(CELLS))

endmodule

bind texture_coverage_histogram tch_checker u_tch_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the texture coverage histogram: directed table, then random meshes.
module testbench;
  import tch_pkg::*;

  localparam int ONE_Q16    = 1 << FRAC_W;
  localparam int LATENCY    = 2;
  localparam int RAND_ITEMS = 550;
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_LEN   = 120;
  localparam int DIR_ROWS   = 16;

  typedef struct packed {
    logic [CNT_W-1:0] vertices;
    logic [CNT_W-1:0] outside;
    logic [COV_W-1:0] covered;
  } mesh_tally_t;

  typedef struct packed {
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] t;
    logic               last;
    logic               typed;
    mesh_tally_t        tally;
  } dir_row_t;

  // Rows with typed set carry a tally that can be read straight off the coordinates.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{24'd1, 24'd0, 9'd1}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, '{24'd1, 24'd1, 9'd0}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, '{24'd1, 24'd1, 9'd0}},
    '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1, '{24'd2, 24'd2, 9'd0}},
    '{32'hFFFF_FFFF, 32'hFFFF_E667, 1'b1, 1'b1, '{24'd1, 24'd0, 9'd1}},
    '{32'hFFFF_E666, 32'h0000_0000, 1'b1, 1'b1, '{24'd1, 24'd1, 9'd0}},
    '{32'h0000_FFFF, 32'h0000_FFFF, 1'b0, 1'b0, '0},
    '{32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_FFFF, 32'h0000_FFFF, 1'b1, 1'b1, '{24'd3, 24'd1, 9'd1}},
    '{32'h0000_1999, 32'h0000_4CCD, 1'b0, 1'b0, '0},
    '{32'h0000_8000, 32'h0000_8000, 1'b0, 1'b0, '0},
    '{32'h0000_8000, 32'h0000_8000, 1'b0, 1'b0, '0},
    '{32'h0000_CCCC, 32'h0000_3333, 1'b0, 1'b0, '0},
    '{32'h1234_5678, 32'hEDCB_A988, 1'b0, 1'b0, '0},
    '{32'h0000_199A, 32'h0000_199A, 1'b1, 1'b0, '0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_tex_s = '0;
  logic signed [COORD_W-1:0] in_tex_t = '0;
  logic                      in_last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic        [CNT_W-1:0]   out_vertex_count;
  logic        [CNT_W-1:0]   out_outside_count;
  logic        [COV_W-1:0]   out_covered_cells;

  texture_coverage_histogram dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_tex_s          (in_tex_s),
    .in_tex_t          (in_tex_t),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_count  (out_vertex_count),
    .out_outside_count (out_outside_count),
    .out_covered_cells (out_covered_cells)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the coverage map and counters of the mesh in progress.
  bit               hit_map [CELLS];
  logic [CNT_W-1:0] vtx_run;
  logic [CNT_W-1:0] outside_run;
  logic [COV_W-1:0] covered_run;

  mesh_tally_t tally_q [$];
  bit          no_gaps = 1'b0;
  bit          hold_start = 1'b0;
  int          stall_left = 0;
  int          fail_count = 0;
  int          results_seen = 0;
  int          vertices_sent = 0;
  int          meshes_sent = 0;
  int          outside_sent = 0;
  int          best_cover = 0;
  int          cycle_count = 0;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

  // Grid index of one coordinate, truncated towards zero; -1 when off the grid.
  function automatic int grid_index(input logic signed [COORD_W-1:0] c);
    longint scaled;
    longint idx;
    scaled = longint'(c) * GRID_SIZE;
    idx    = scaled / ONE_Q16;
    if (idx < 0 || idx >= GRID_SIZE) return -1;
    return int'(idx);
  endfunction

  function automatic void clear_mesh();
    foreach (hit_map[i]) hit_map[i] = 1'b0;
    vtx_run     = '0;
    outside_run = '0;
    covered_run = '0;
  endfunction

  // Folds one vertex into the running mesh; returns 1 with the tally when the mesh closes.
  function automatic bit tally_vertex(input logic [COORD_W-1:0] s, input logic [COORD_W-1:0] t,
                                      input logic last, output mesh_tally_t res);
    int si;
    int ti;
    si      = grid_index(s);
    ti      = grid_index(t);
    res     = '0;
    vtx_run = bump(vtx_run);
    if (si < 0 || ti < 0) begin
      outside_run = bump(outside_run);
      outside_sent++;
    end else if (!hit_map[si * GRID_SIZE + ti]) begin
      hit_map[si * GRID_SIZE + ti] = 1'b1;
      covered_run = covered_run + COV_W'(1);
    end
    if (!last) return 1'b0;
    res = '{vtx_run, outside_run, covered_run};
    if (int'(covered_run) > best_cover) best_cover = int'(covered_run);
    clear_mesh();
    return 1'b1;
  endfunction

  task automatic send_vertex(input logic [COORD_W-1:0] s, input logic [COORD_W-1:0] t,
                             input logic last, input bit typed, input mesh_tally_t typed_res);
    mesh_tally_t res;
    while (!no_gaps && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tex_s <= s;
    in_tex_t <= t;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    vertices_sent++;
    if (tally_vertex(s, t, last, res)) begin
      meshes_sent++;
      tally_q.push_back(typed ? typed_res : res);
    end
    @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    int v;
    case ($urandom_range(99)) inside
      [0:64]:  v = $urandom_range(0, ONE_Q16 - 1);
      [65:79]: v = ($urandom_range(0, GRID_SIZE) * ONE_Q16) / GRID_SIZE
                   + int'($urandom_range(0, 8)) - 4;
      [80:87]: v = -int'($urandom_range(1, ONE_Q16 / GRID_SIZE));
      [88:94]: v = $urandom;
      default: v = $urandom_range(0, 1) ? ONE_Q16 + int'($urandom_range(0, 20000))
                                        : -ONE_Q16 / GRID_SIZE - int'($urandom_range(1, 20000));
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (tally_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // Receiver: random back-pressure, with a long hold-off when one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_start) begin
        stall_left = HOLD_LEN;
        hold_start = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= 31);
      end
    end
  end

  function automatic void check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    mesh_tally_t exp_t;
    if (rst_n && out_valid && out_ready) begin
      if (tally_q.size() == 0) begin
        $error("result transfer with no mesh pending");
        fail_count++;
      end else begin
        exp_t = tally_q.pop_front();
        check_field("vertex_count", int'(exp_t.vertices), int'(out_vertex_count));
        check_field("outside_count", int'(exp_t.outside), int'(out_outside_count));
        check_field("covered_cells", int'(exp_t.covered), int'(out_covered_cells));
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int mesh_len;
    clear_mesh();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_TAB[r])
      send_vertex(DIR_TAB[r].s, DIR_TAB[r].t, DIR_TAB[r].last, DIR_TAB[r].typed,
                  DIR_TAB[r].tally);

    // The receiver holds off while short meshes keep coming, so a second last vertex
    // must wait at the input until the pending result transfer completes.
    no_gaps    = 1'b1;
    hold_start = 1'b1;
    repeat (8) begin
      mesh_len = $urandom_range(1, 3);
      for (int i = 0; i < mesh_len; i++)
        send_vertex(pick_coord(), pick_coord(), i == mesh_len - 1, 1'b0, '0);
    end
    no_gaps = 1'b0;

    // One mesh that visits every cell, closed by a vertex off the grid.
    for (int si = 0; si < GRID_SIZE; si++)
      for (int ti = 0; ti < GRID_SIZE; ti++)
        send_vertex((si * ONE_Q16) / GRID_SIZE + int'($urandom_range(100, 6000)),
                    (ti * ONE_Q16) / GRID_SIZE + int'($urandom_range(100, 6000)),
                    1'b0, 1'b0, '0);
    send_vertex(32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, '0);

    in_valid <= 1'b0;
    wait_drained();

    while (vertices_sent < DIR_ROWS + RAND_ITEMS) begin
      no_gaps  = (vertices_sent >= 380 && vertices_sent < 470);
      mesh_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < mesh_len; i++)
        send_vertex(pick_coord(), pick_coord(), i == mesh_len - 1, 1'b0, '0);
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;
    wait_drained();

    $display("Sent %0d vertices in %0d meshes, %0d of them off the grid; %0d results checked.",
             vertices_sent, meshes_sent, outside_sent, results_seen);
    $display("Largest coverage within one mesh: %0d of %0d cells.", best_cover, CELLS);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> texture_coverage_histogram.f
+incdir+hw/rtl
hw/rtl/tch_pkg.sv
hw/rtl/texture_coverage_histogram.sv
hw/rtl/tch_checker.sv
tb/testbench.sv
